// ===== rtl/ciu_pkg.sv =====
// ----------------------------------------------------------------------------
// ciu_pkg
// Types, codes and helper functions shared by the compare instruction unit.
// ----------------------------------------------------------------------------
package ciu_pkg;

    localparam logic [1:0] CMD_CMPI  = 2'd0;
    localparam logic [1:0] CMD_CMPM  = 2'd1;
    localparam logic [1:0] CMD_CMPA  = 2'd2;
    localparam logic [1:0] CMD_REGWR = 2'd3;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;
    localparam logic [1:0] SIZE_LONG = 2'd2;
    localparam logic [1:0] SIZE_BAD  = 2'd3;

    localparam logic [2:0] MODE_DREG    = 3'd0;
    localparam logic [2:0] MODE_AREG    = 3'd1;
    localparam logic [2:0] MODE_AIND    = 3'd2;
    localparam logic [2:0] MODE_POSTINC = 3'd3;
    localparam logic [2:0] MODE_PREDEC  = 3'd4;
    localparam logic [2:0] MODE_DISP    = 3'd5;
    localparam logic [2:0] MODE_INDEX   = 3'd6;
    localparam logic [2:0] MODE_EXT     = 3'd7;

    localparam logic [2:0] XREG_ABSW    = 3'd0;
    localparam logic [2:0] XREG_ABSL    = 3'd1;
    localparam logic [2:0] XREG_PCDISP  = 3'd2;
    localparam logic [2:0] XREG_PCINDEX = 3'd3;
    localparam logic [2:0] XREG_IMM     = 3'd4;
    localparam logic [2:0] XREG_CMPA_MAX = 3'd4;

    localparam logic [2:0] SP_REG = 3'd7;

    localparam int RF_DEPTH = 16;
    localparam int RF_AW    = 4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  size;
        logic [2:0]  ea_mode;
        logic [2:0]  ea_reg;
        logic [2:0]  dest_reg;
        logic [31:0] ext_word;
        logic [31:0] imm_value;
        logic [31:0] mem_src;
        logic [31:0] mem_dst;
        logic [31:0] pc;
        logic [3:0]  reg_index;
        logic [31:0] reg_wdata;
    } ciu_in_t;

    typedef struct packed {
        logic [31:0] src_address;
        logic [31:0] dst_address;
        logic        flag_n;
        logic        flag_z;
        logic        flag_v;
        logic        flag_c;
        logic        bad_mode;
    } ciu_out_t;

    typedef struct packed {
        logic             en;
        logic [RF_AW-1:0] addr;
        logic [31:0]      data;
    } rf_wr_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] opnd;
        logic        wb_en;
        logic [31:0] wb_val;
    } agu_res_t;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sx8(input logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

    // byte steps on the stack pointer keep it word aligned
    function automatic logic [2:0] step_of(input logic [2:0] r, input logic [1:0] size);
        logic [2:0] st;
        unique case (size)
            SIZE_BYTE: st = (r == SP_REG) ? 3'd2 : 3'd1;
            SIZE_WORD: st = 3'd2;
            default:   st = 3'd4;
        endcase
        return st;
    endfunction

    // {N, Z, V, C} of d - s at the given size
    function automatic logic [3:0] cond_codes(input logic [31:0] d, input logic [31:0] s,
                                              input logic [1:0] size);
        logic [31:0] m;
        logic [31:0] top;
        logic [31:0] dm;
        logic [31:0] sm;
        logic [31:0] r;
        logic [32:0] diff;
        unique case (size)
            SIZE_BYTE: m = 32'h0000_00FF;
            SIZE_WORD: m = 32'h0000_FFFF;
            default:   m = 32'hFFFF_FFFF;
        endcase
        top  = m ^ (m >> 1);
        dm   = d & m;
        sm   = s & m;
        diff = {1'b0, dm} - {1'b0, sm};
        r    = diff[31:0] & m;
        return {|(r & top), (r == 32'd0), |((dm ^ sm) & (dm ^ r) & top), diff[32]};
    endfunction

endpackage

// ===== rtl/ciu_ram.sv =====
// ----------------------------------------------------------------------------
// ciu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ciu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/ciu_regfile.sv =====
// ----------------------------------------------------------------------------
// ciu_regfile
// D0-D7 / A0-A7 register file: two RAM copies for two read ports, one
// write port, per-entry valid bits so unwritten entries read as zero.
// ----------------------------------------------------------------------------
module ciu_regfile
    import ciu_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  rf_wr_t           wr,
    input  logic [RF_AW-1:0] rd_addr_a,
    input  logic [RF_AW-1:0] rd_addr_b,
    output logic [31:0]      rd_data_a,
    output logic [31:0]      rd_data_b
);

    logic [RF_DEPTH-1:0] valid_reg;
    logic                rd_valid_a_reg;
    logic                rd_valid_b_reg;
    logic [31:0]         ram_q_a;
    logic [31:0]         ram_q_b;

    ciu_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_ram_a (
        .clk   (aclk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .raddr (rd_addr_a),
        .rdata (ram_q_a)
    );

    ciu_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_ram_b (
        .clk   (aclk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .raddr (rd_addr_b),
        .rdata (ram_q_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            rd_valid_a_reg <= 1'b0;
            rd_valid_b_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_valid_a_reg <= valid_reg[rd_addr_a];
            rd_valid_b_reg <= valid_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_valid_a_reg ? ram_q_a : 32'd0;
    assign rd_data_b = rd_valid_b_reg ? ram_q_b : 32'd0;

endmodule

// ===== rtl/ciu_agu.sv =====
// ----------------------------------------------------------------------------
// ciu_agu
// Effective address unit: address, operand and pointer update for all
// twelve addressing modes, from the base and index register reads.
// ----------------------------------------------------------------------------
module ciu_agu
    import ciu_pkg::*;
(
    input  ciu_in_t     item,
    input  logic [31:0] qa,
    input  logic [31:0] qb,
    output agu_res_t    res
);

    logic [31:0] step;
    logic [31:0] disp16;
    logic [31:0] index_val;
    logic [31:0] index_sum;

    always_comb begin
        step      = {29'd0, step_of(item.ea_reg, item.size)};
        disp16    = sx16(item.ext_word[15:0]);
        index_val = item.ext_word[11] ? qb : sx16(qb[15:0]);
        index_sum = index_val + sx8(item.ext_word[7:0]);

        res.addr   = 32'd0;
        res.opnd   = item.mem_src;
        res.wb_en  = 1'b0;
        res.wb_val = qa + step;

        unique case (item.ea_mode) inside
            MODE_DREG, MODE_AREG: begin
                res.opnd = qa;
            end
            MODE_AIND: begin
                res.addr = qa;
            end
            MODE_POSTINC: begin
                res.addr  = qa;
                res.wb_en = 1'b1;
            end
            MODE_PREDEC: begin
                res.wb_val = qa - step;
                res.addr   = qa - step;
                res.wb_en  = 1'b1;
            end
            MODE_DISP: begin
                res.addr = qa + disp16;
            end
            MODE_INDEX: begin
                res.addr = qa + index_sum;
            end
            default: begin
                unique case (item.ea_reg)
                    XREG_ABSW:    res.addr = disp16;
                    XREG_ABSL:    res.addr = item.ext_word;
                    XREG_PCDISP:  res.addr = item.pc + disp16;
                    XREG_PCINDEX: res.addr = item.pc + index_sum;
                    default:      res.opnd = item.imm_value;
                endcase
            end
        endcase
    end

endmodule

// ===== rtl/compare_instruction_unit.sv =====
// ----------------------------------------------------------------------------
// compare_instruction_unit
// CMPI / CMPA / CMPM execution with register file and condition codes.
// ----------------------------------------------------------------------------
// Input items arrive on s_valid/s_ready/s_data, results leave on
// m_valid/m_ready/m_data, one result per item. A one-item input buffer
// takes the next item while the current one executes, and the output
// register holds a result until the receiver takes it.
// Register file: D0-D7/A0-A7 in two RAM copies with registered reads.
// Each item starts from the input buffer, where the first register reads
// are issued. Register writes and rejected items finish there; CMPI goes
// through ST_EX, CMPA through ST_EX and ST_CMPA (a further read of An on
// port A), CMPM through ST_EX and ST_WB2 (second write-back of Ax). The
// result is registered by the last of these except for CMPM, whose result
// is registered in ST_EX. The states each instruction passes through
// follow from the reads and writes it needs on the two read ports and one write port.
// Reset (aresetn low, synchronous) clears the flags to zero and makes all
// registers read as zero through per-entry valid bits; no clearing pass is needed.
// If the receiver stalls, the result waits in the output register, the
// next item waits in the input buffer without starting, and s_ready drops
// once the input buffer is full.
// ----------------------------------------------------------------------------
module compare_instruction_unit
    import ciu_pkg::*;
#(
    parameter int ADDR_WIDTH = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ciu_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ciu_out_t m_data
);

    localparam logic [31:0] ADDR_MASK = 32'hFFFF_FFFF >> (32 - ADDR_WIDTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EX   = 2'd1;
    localparam logic [1:0] ST_CMPA = 2'd2;
    localparam logic [1:0] ST_WB2  = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic        buf_valid_reg, buf_valid_next;
    ciu_in_t     buf_reg;
    ciu_in_t     cur_reg, cur_next;
    logic        out_valid_reg, out_valid_next;
    ciu_out_t    out_reg, out_next;
    logic [3:0]  flags_reg, flags_next;
    agu_res_t    hold_reg, hold_next;
    logic [31:0] ax_wb_reg, ax_wb_next;

    logic             out_free;
    logic             start;
    logic             start_bad;
    logic             s_take;
    rf_wr_t           rf_wr;
    logic [RF_AW-1:0] rd_addr_a;
    logic [RF_AW-1:0] rd_addr_b;
    logic [31:0]      qa;
    logic [31:0]      qb;
    agu_res_t         agu;
    logic [31:0]      ay_new;
    logic [31:0]      ax_cur;
    logic [31:0]      an_val;
    logic [31:0]      cmpa_src;
    logic [3:0]       cc;

    ciu_regfile u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (rf_wr),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (qa),
        .rd_data_b (qb)
    );

    ciu_agu u_agu (
        .item (cur_reg),
        .qa   (qa),
        .qb   (qb),
        .res  (agu)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign start    = (state_reg == ST_IDLE) && buf_valid_reg && out_free;
    assign s_ready  = !buf_valid_reg || start;
    assign s_take   = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    always_comb begin
        start_bad = 1'b0;
        if (buf_reg.cmd != CMD_REGWR) begin
            if (buf_reg.size == SIZE_BAD) begin
                start_bad = 1'b1;
            end else if (buf_reg.cmd == CMD_CMPI) begin
                start_bad = (buf_reg.ea_mode == MODE_AREG) ||
                            ((buf_reg.ea_mode == MODE_EXT) &&
                             (buf_reg.ea_reg >= XREG_PCDISP));
            end else if (buf_reg.cmd == CMD_CMPA) begin
                start_bad = (buf_reg.size == SIZE_BYTE) ||
                            ((buf_reg.ea_mode == MODE_EXT) &&
                             (buf_reg.ea_reg > XREG_CMPA_MAX));
            end
        end
    end

    always_comb begin
        if (state_reg == ST_EX) begin
            rd_addr_a = {1'b1, cur_reg.dest_reg};
        end else if ((buf_reg.cmd != CMD_CMPM) && (buf_reg.ea_mode == MODE_DREG)) begin
            rd_addr_a = {1'b0, buf_reg.ea_reg};
        end else begin
            rd_addr_a = {1'b1, buf_reg.ea_reg};
        end
        if (buf_reg.cmd == CMD_CMPM) begin
            rd_addr_b = {1'b1, buf_reg.dest_reg};
        end else begin
            rd_addr_b = {buf_reg.ext_word[15], buf_reg.ext_word[14:12]};
        end
    end

    always_comb begin
        ay_new   = qa + {29'd0, step_of(cur_reg.ea_reg, cur_reg.size)};
        ax_cur   = (cur_reg.dest_reg == cur_reg.ea_reg) ? ay_new : qb;
        an_val   = (hold_reg.wb_en && (cur_reg.dest_reg == cur_reg.ea_reg)) ?
                   hold_reg.wb_val : qa;
        cmpa_src = (cur_reg.size == SIZE_WORD) ? sx16(hold_reg.opnd[15:0]) : hold_reg.opnd;
        unique case (state_reg)
            ST_CMPA: cc = cond_codes(an_val, cmpa_src, SIZE_LONG);
            default: begin
                if (cur_reg.cmd == CMD_CMPM) begin
                    cc = cond_codes(cur_reg.mem_dst, cur_reg.mem_src, cur_reg.size);
                end else begin
                    cc = cond_codes(agu.opnd, cur_reg.imm_value, cur_reg.size);
                end
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        buf_valid_next = buf_valid_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        flags_next     = flags_reg;
        hold_next      = hold_reg;
        ax_wb_next     = ax_wb_reg;
        rf_wr          = '0;

        if (m_valid && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (s_take) begin
            buf_valid_next = 1'b1;
        end else if (start) begin
            buf_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    if (buf_reg.cmd == CMD_REGWR) begin
                        rf_wr.en   = 1'b1;
                        rf_wr.addr = buf_reg.reg_index;
                        rf_wr.data = buf_reg.reg_wdata;
                        out_valid_next = 1'b1;
                        out_next = {32'd0, 32'd0, flags_reg, 1'b0};
                    end else if (start_bad) begin
                        out_valid_next = 1'b1;
                        out_next = {32'd0, 32'd0, flags_reg, 1'b1};
                    end else begin
                        cur_next   = buf_reg;
                        state_next = ST_EX;
                    end
                end
            end
            ST_EX: begin
                if (cur_reg.cmd == CMD_CMPM) begin
                    rf_wr.en   = 1'b1;
                    rf_wr.addr = {1'b1, cur_reg.ea_reg};
                    rf_wr.data = ay_new;
                    ax_wb_next = ax_cur + {29'd0, step_of(cur_reg.dest_reg, cur_reg.size)};
                    flags_next = cc;
                    out_valid_next = 1'b1;
                    out_next = {qa & ADDR_MASK, ax_cur & ADDR_MASK, cc, 1'b0};
                    state_next = ST_WB2;
                end else begin
                    rf_wr.en   = agu.wb_en;
                    rf_wr.addr = {1'b1, cur_reg.ea_reg};
                    rf_wr.data = agu.wb_val;
                    if (cur_reg.cmd == CMD_CMPA) begin
                        hold_next  = agu;
                        state_next = ST_CMPA;
                    end else begin
                        flags_next = cc;
                        out_valid_next = 1'b1;
                        out_next = {agu.addr & ADDR_MASK, 32'd0, cc, 1'b0};
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CMPA: begin
                flags_next = cc;
                out_valid_next = 1'b1;
                out_next = {hold_reg.addr & ADDR_MASK, 32'd0, cc, 1'b0};
                state_next = ST_IDLE;
            end
            default: begin
                rf_wr.en   = 1'b1;
                rf_wr.addr = {1'b1, cur_reg.dest_reg};
                rf_wr.data = ax_wb_reg;
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            buf_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= 4'd0;
        end else begin
            state_reg     <= state_next;
            buf_valid_reg <= buf_valid_next;
            out_valid_reg <= out_valid_next;
            flags_reg     <= flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            buf_reg <= s_data;
        end
        cur_reg   <= cur_next;
        out_reg   <= out_next;
        hold_reg  <= hold_next;
        ax_wb_reg <= ax_wb_next;
    end

`ifndef SYNTHESIS
    a_out_empty_mid_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EX || state_reg == ST_CMPA) |-> !out_valid_reg)
        else $error("output register busy while an item is in flight");

    a_start_progress: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> (state_reg != ST_IDLE) || out_valid_reg)
        else $error("started item neither executing nor delivered");

    a_bad_keeps_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (start && start_bad) |=> $stable(flags_reg))
        else $error("rejected item changed the condition flags");
`endif

endmodule

// ===== bench/ciu_checker.sv =====
// ----------------------------------------------------------------------------
// ciu_checker
// Watches both channels of the compare instruction unit. It keeps its own
// copy of the register file and condition codes, predicts the result of each
// accepted item and compares every returned result field by field, in order.
// ----------------------------------------------------------------------------
module ciu_checker
    import ciu_pkg::*;
#(
    parameter int ADDR_WIDTH = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  ciu_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  ciu_out_t m_data,
    output int       err_count,
    output int       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] ADDR_MASK = (ADDR_WIDTH >= 32) ? 32'hFFFF_FFFF :
                                        32'((64'd1 << ADDR_WIDTH) - 64'd1);

    logic [31:0] dreg_file [8];
    logic [31:0] areg_file [8];
    logic [3:0]  ccr;
    ciu_out_t    expected_q [$];

    function automatic logic [31:0] sext16(input logic [31:0] v);
        return {{16{v[15]}}, v[15:0]};
    endfunction

    function automatic logic [31:0] sext8(input logic [31:0] v);
        return {{24{v[7]}}, v[7:0]};
    endfunction

    function automatic logic [31:0] size_mask(input logic [1:0] sz);
        if (sz == SIZE_BYTE) return 32'h0000_00FF;
        if (sz == SIZE_WORD) return 32'h0000_FFFF;
        return 32'hFFFF_FFFF;
    endfunction

    // {N, Z, V, C} of d - s
    function automatic logic [3:0] subtract_flags(input logic [31:0] d, input logic [31:0] s,
                                                  input logic [1:0] sz);
        logic [31:0] m;
        logic [31:0] msb;
        logic [31:0] dm;
        logic [31:0] sm;
        logic [31:0] r;
        m   = size_mask(sz);
        msb = m ^ (m >> 1);
        dm  = d & m;
        sm  = s & m;
        r   = (dm - sm) & m;
        return {(r & msb) != 0, r == 0, ((dm ^ sm) & (dm ^ r) & msb) != 0, sm > dm};
    endfunction

    // byte steps on A7 keep the stack word aligned
    function automatic logic [31:0] ptr_step(input logic [2:0] r, input logic [1:0] sz);
        if (sz == SIZE_WORD) return 32'd2;
        if (sz == SIZE_BYTE) return (r == SP_REG) ? 32'd2 : 32'd1;
        return 32'd4;
    endfunction

    function automatic logic [31:0] index_offset(input logic [31:0] ext);
        logic [2:0]  r;
        logic [31:0] v;
        r = ext[14:12];
        v = ext[15] ? areg_file[r] : dreg_file[r];
        if (!ext[11]) v = sext16(v);
        return v + sext8(ext);
    endfunction

    function automatic logic [31:0] resolve_ea(input ciu_in_t it, output logic [31:0] opnd);
        logic [2:0]  r;
        logic [31:0] a;
        r    = it.ea_reg;
        a    = '0;
        opnd = it.mem_src;
        case (it.ea_mode)
            MODE_DREG: begin
                opnd = dreg_file[r];
                return '0;
            end
            MODE_AREG: begin
                opnd = areg_file[r];
                return '0;
            end
            MODE_AIND:    a = areg_file[r];
            MODE_POSTINC: begin
                a = areg_file[r];
                areg_file[r] = areg_file[r] + ptr_step(r, it.size);
            end
            MODE_PREDEC: begin
                areg_file[r] = areg_file[r] - ptr_step(r, it.size);
                a = areg_file[r];
            end
            MODE_DISP:  a = areg_file[r] + sext16(it.ext_word);
            MODE_INDEX: a = areg_file[r] + index_offset(it.ext_word);
            default: begin
                case (r)
                    XREG_ABSW:    a = sext16(it.ext_word);
                    XREG_ABSL:    a = it.ext_word;
                    XREG_PCDISP:  a = it.pc + sext16(it.ext_word);
                    XREG_PCINDEX: a = it.pc + index_offset(it.ext_word);
                    default: begin
                        opnd = it.imm_value;
                        return '0;
                    end
                endcase
            end
        endcase
        return a & ADDR_MASK;
    endfunction

    function automatic ciu_out_t compare_result(input ciu_in_t it);
        ciu_out_t    res;
        logic        bad;
        logic [31:0] opnd;
        res = '0;
        bad = 1'b0;
        if (it.cmd == CMD_REGWR) begin
            if (it.reg_index[3]) areg_file[it.reg_index[2:0]] = it.reg_wdata;
            else dreg_file[it.reg_index[2:0]] = it.reg_wdata;
        end else if (it.size == SIZE_BAD) begin
            bad = 1'b1;
        end else if (it.cmd == CMD_CMPM) begin
            res.src_address = areg_file[it.ea_reg] & ADDR_MASK;
            areg_file[it.ea_reg] = areg_file[it.ea_reg] + ptr_step(it.ea_reg, it.size);
            res.dst_address = areg_file[it.dest_reg] & ADDR_MASK;
            areg_file[it.dest_reg] = areg_file[it.dest_reg] + ptr_step(it.dest_reg, it.size);
            ccr = subtract_flags(it.mem_dst, it.mem_src, it.size);
        end else if (it.cmd == CMD_CMPI) begin
            if (it.ea_mode == MODE_AREG ||
                (it.ea_mode == MODE_EXT && it.ea_reg >= XREG_PCDISP)) begin
                bad = 1'b1;
            end else begin
                res.src_address = resolve_ea(it, opnd);
                ccr = subtract_flags(opnd, it.imm_value, it.size);
            end
        end else begin
            if (it.size == SIZE_BYTE ||
                (it.ea_mode == MODE_EXT && it.ea_reg > XREG_CMPA_MAX)) begin
                bad = 1'b1;
            end else begin
                res.src_address = resolve_ea(it, opnd);
                if (it.size == SIZE_WORD) opnd = sext16(opnd);
                // An is read after the source mode has updated it
                ccr = subtract_flags(areg_file[it.dest_reg], opnd, SIZE_LONG);
            end
        end
        res.flag_n   = ccr[3];
        res.flag_z   = ccr[2];
        res.flag_v   = ccr[1];
        res.flag_c   = ccr[0];
        res.bad_mode = bad;
        return res;
    endfunction

    task automatic note_error(input string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        err_count++;
    endtask

    task automatic cmp_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
        if (got !== want)
            note_error($sformatf("%s got %h expected %h", name, got, want));
    endtask

    always @(posedge aclk) begin
        ciu_out_t want;
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                dreg_file[i] = '0;
                areg_file[i] = '0;
            end
            ccr = '0;
            expected_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    note_error("result with no item outstanding");
                end else begin
                    want = expected_q.pop_front();
                    cmp_field("src_address", m_data.src_address, want.src_address);
                    cmp_field("dst_address", m_data.dst_address, want.dst_address);
                    cmp_field("flag_n", 32'(m_data.flag_n), 32'(want.flag_n));
                    cmp_field("flag_z", 32'(m_data.flag_z), 32'(want.flag_z));
                    cmp_field("flag_v", 32'(m_data.flag_v), 32'(want.flag_v));
                    cmp_field("flag_c", 32'(m_data.flag_c), 32'(want.flag_c));
                    cmp_field("bad_mode", 32'(m_data.bad_mode), 32'(want.bad_mode));
                end
            end
            if (s_valid && s_ready) expected_q.push_back(compare_result(s_data));
        end
        pending <= expected_q.size();
    end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the compare instruction unit: a directed pass over the
// addressing modes, sizes and illegal combinations, then random register
// loads and compares with random gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module tb_top
    import ciu_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AW           = 32;
    localparam int RANDOM_ITEMS = 1300;
    localparam int CYCLE_LIMIT  = 600000;

    logic     aclk;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    ciu_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    ciu_out_t m_data;
    int       err_count;
    int       pending;
    logic     quiet   = 1'b0;
    int       hold_cnt = 0;
    int       cycle_count = 0;

    logic [31:0] corner_vals [12] = '{
        32'h0000_0000, 32'h0000_0001, 32'h0000_007F, 32'h0000_0080,
        32'h0000_00FF, 32'h0000_7FFF, 32'h0000_8000, 32'h0000_FFFF,
        32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FF80
    };

    compare_instruction_unit #(.ADDR_WIDTH(AW)) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    ciu_checker #(.ADDR_WIDTH(AW)) checker_i (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .err_count (err_count),
        .pending   (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // output stalls: mostly short, now and then long
    always @(posedge aclk) begin
        int r;
        r = $urandom_range(0, 99);
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (quiet || r < 65) begin
            m_ready <= 1'b1;
        end else begin
            m_ready  <= 1'b0;
            hold_cnt <= (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 30);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return corner_vals[$urandom_range(0, 11)];
        if (r < 6) return 32'($urandom_range(0, 15));
        return $urandom;
    endfunction

    function automatic ciu_in_t regwr_item(input logic [3:0] idx, input logic [31:0] val);
        ciu_in_t it;
        it           = '0;
        it.cmd       = CMD_REGWR;
        it.ext_word  = $urandom;
        it.pc        = $urandom;
        it.reg_index = idx;
        it.reg_wdata = val;
        return it;
    endfunction

    function automatic ciu_in_t cmp_item(input logic [1:0] cmd, input logic [1:0] sz,
                                         input logic [2:0] mode, input logic [2:0] ea_r,
                                         input logic [2:0] dst_r, input logic [31:0] ext,
                                         input logic [31:0] imm, input logic [31:0] src,
                                         input logic [31:0] dst);
        ciu_in_t it;
        it           = '0;
        it.cmd       = cmd;
        it.size      = sz;
        it.ea_mode   = mode;
        it.ea_reg    = ea_r;
        it.dest_reg  = dst_r;
        it.ext_word  = ext;
        it.imm_value = imm;
        it.mem_src   = src;
        it.mem_dst   = dst;
        it.pc        = $urandom;
        it.reg_index = 4'($urandom_range(0, 15));
        it.reg_wdata = $urandom;
        return it;
    endfunction

    function automatic ciu_in_t random_item();
        ciu_in_t it;
        int      k;
        int      r;
        it.ea_mode   = 3'($urandom_range(0, 7));
        it.ea_reg    = 3'($urandom_range(0, 7));
        it.dest_reg  = 3'($urandom_range(0, 7));
        it.ext_word  = $urandom;
        it.imm_value = pick_value();
        it.mem_src   = pick_value();
        it.mem_dst   = pick_value();
        it.pc        = $urandom;
        it.reg_index = 4'($urandom_range(0, 15));
        it.reg_wdata = pick_value();
        k = $urandom_range(0, 99);
        if (k < 15) it.cmd = CMD_REGWR;
        else if (k < 45) it.cmd = CMD_CMPI;
        else if (k < 75) it.cmd = CMD_CMPA;
        else it.cmd = CMD_CMPM;
        r = $urandom_range(0, 99);
        if (r < 3) it.size = SIZE_BAD;
        else if (it.cmd == CMD_CMPA) it.size = (r < 8) ? SIZE_BYTE :
                                               (r < 54) ? SIZE_WORD : SIZE_LONG;
        else it.size = 2'($urandom_range(0, 2));
        if ($urandom_range(0, 3) == 0) it.mem_dst = it.mem_src;
        if ($urandom_range(0, 3) == 0) it.imm_value = it.mem_src;
        return it;
    endfunction

    task automatic push_item(input ciu_in_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        push_item(regwr_item(4'd0, 32'h0000_0080));
        push_item(regwr_item(4'd7, 32'hFFFF_FFFF));
        push_item(regwr_item(4'd8, 32'h0000_1000));
        push_item(regwr_item(4'd15, 32'h0000_2000));
        push_item(regwr_item(4'd11, 32'hFFFF_FFFE));
        push_item(cmp_item(CMD_CMPI, SIZE_BYTE, MODE_DREG, 3'd0, 3'd0, 0, 32'h80, 0, 0));
        push_item(cmp_item(CMD_CMPI, SIZE_WORD, MODE_DREG, 3'd7, 3'd0, 0, 32'h1, 0, 0));
        push_item(cmp_item(CMD_CMPI, SIZE_LONG, MODE_DREG, 3'd0, 3'd0, 0,
                           32'h8000_0001, 0, 0));
        push_item(cmp_item(CMD_CMPI, SIZE_BYTE, MODE_POSTINC, 3'd7, 3'd0, 0, 32'h7F,
                           32'h80, 0));
        push_item(cmp_item(CMD_CMPI, SIZE_BYTE, MODE_PREDEC, 3'd7, 3'd0, 0, 32'hFF,
                           32'h00, 0));
        push_item(cmp_item(CMD_CMPI, SIZE_WORD, MODE_DISP, 3'd0, 3'd0, 32'h0000_8000,
                           32'h8000, 32'h7FFF, 0));
        push_item(cmp_item(CMD_CMPI, SIZE_LONG, MODE_INDEX, 3'd0, 3'd0, 32'h0000_7080,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
        push_item(cmp_item(CMD_CMPI, SIZE_WORD, MODE_EXT, XREG_ABSW, 3'd0, 32'h0000_8000,
                           32'h0, 32'h0, 0));
        push_item(cmp_item(CMD_CMPI, SIZE_LONG, MODE_EXT, XREG_ABSL, 3'd0, 32'hFFFF_FFFF,
                           32'h7FFF_FFFF, 32'h8000_0000, 0));
        push_item(cmp_item(CMD_CMPI, SIZE_LONG, MODE_AREG, 3'd0, 3'd0, 0, 0, 0, 0));
        push_item(cmp_item(CMD_CMPI, SIZE_WORD, MODE_EXT, XREG_PCDISP, 3'd0, 0, 0, 0, 0));
        push_item(cmp_item(CMD_CMPI, SIZE_WORD, MODE_EXT, XREG_IMM, 3'd0, 0, 0, 0, 0));
        push_item(cmp_item(CMD_CMPI, SIZE_BAD, MODE_DREG, 3'd0, 3'd0, 0, 0, 0, 0));
        push_item(cmp_item(CMD_CMPA, SIZE_WORD, MODE_EXT, XREG_IMM, 3'd0, 0, 32'h0000_8000,
                           0, 0));
        push_item(cmp_item(CMD_CMPA, SIZE_LONG, MODE_EXT, XREG_PCINDEX, 3'd3, 32'h0000_B87F,
                           0, 32'hFFFF_FFFE, 0));
        push_item(cmp_item(CMD_CMPA, SIZE_LONG, MODE_EXT, XREG_PCDISP, 3'd1, 32'h0000_7FFE,
                           0, 32'h0000_1000, 0));
        push_item(cmp_item(CMD_CMPA, SIZE_BYTE, MODE_DREG, 3'd0, 3'd0, 0, 0, 0, 0));
        push_item(cmp_item(CMD_CMPA, SIZE_LONG, MODE_EXT, 3'd5, 3'd0, 0, 0, 0, 0));
        push_item(cmp_item(CMD_CMPA, SIZE_WORD, MODE_POSTINC, 3'd0, 3'd0, 0, 0,
                           32'h0000_1000, 0));
        push_item(cmp_item(CMD_CMPM, SIZE_BYTE, MODE_DREG, 3'd7, 3'd7, 0, 0, 32'h12,
                           32'h12));
        push_item(cmp_item(CMD_CMPM, SIZE_LONG, MODE_DREG, 3'd2, 3'd3, 0, 0, 32'h1,
                           32'h8000_0000));

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            quiet <= ((i % 250) >= 200);
            push_item(random_item());
        end
        s_valid <= 1'b0;
        quiet   <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
